[hdl/sct_pkg.sv]
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants of the shape collision test core: coordinate
// widths, request kinds and the request and result transaction structs.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned SizeW  = CoordW - 1;
  localparam int unsigned EdgeW  = CoordW + 1;
  localparam int unsigned WideW  = CoordW + 2;
  localparam int unsigned SqW    = 2 * CoordW + 1;
  localparam int unsigned RsqW   = 2 * CoordW;

  typedef enum logic [2:0] {
    ReqBoxBox     = 3'd0,
    ReqCircCirc   = 3'd1,
    ReqBoxCirc    = 3'd2,
    ReqBoxPoint   = 3'd3,
    ReqCircPoint  = 3'd4
  } req_kind_e;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic [SizeW-1:0]         a_w;
    logic [SizeW-1:0]         a_h;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic [SizeW-1:0]         b_w;
    logic [SizeW-1:0]         b_h;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] hit_x;
    logic signed [CoordW-1:0] hit_y;
  } res_t;

endpackage

[hdl/shape_collision_test_core.sv]
// ----------------------------------------------------------------------------
// shape_collision_test_core
// Box, circle and point collision test in signed fixed point. Returns a hit
// flag and a hit point; distances are compared as exact squares.
// ----------------------------------------------------------------------------
//   channel   | ports                  | handshake
//   ----------+------------------------+----------------------------------
//   request   | start, busy, req_i     | taken when start && !busy
//   result    | valid_o, res_o         | one-cycle strobe, no back-pressure
//
// Four register stages: edges, compares and clamps, squares and overlap
// centre, distance compare. One transaction is taken every cycle; busy
// stays low. rst_ni clears the valid bits only.
// ----------------------------------------------------------------------------
module shape_collision_test_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  sct_pkg::req_t req_i,
  output logic          valid_o,
  output sct_pkg::res_t res_o
);

  localparam int unsigned CW = sct_pkg::CoordW;
  localparam int unsigned SW = sct_pkg::SizeW;
  localparam int unsigned EW = sct_pkg::EdgeW;
  localparam int unsigned WW = sct_pkg::WideW;
  localparam int unsigned QW = sct_pkg::SqW;
  localparam int unsigned RW = sct_pkg::RsqW;

  localparam logic signed [CW-1:0] CoordMax = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CoordMin = {1'b1, {(CW-1){1'b0}}};

  // stage 1: edges and sums
  logic                 s1_valid_q, s1_valid_d;
  logic [2:0]           s1_kind_q;
  logic signed [CW-1:0] s1_ax_q, s1_ay_q, s1_bx_q, s1_by_q;
  logic [SW-1:0]        s1_aw_q, s1_bw_q;
  logic signed [EW-1:0] s1_ar_q, s1_ab_q, s1_br_q, s1_bb_q, s1_ar_d, s1_ab_d, s1_br_d, s1_bb_d;
  logic signed [EW-1:0] s1_msx_q, s1_msy_q, s1_msx_d, s1_msy_d;
  logic [CW-1:0]        s1_rsum_q, s1_rsum_d;

  // stage 2: compares, clamps, operand selection
  logic                 s2_valid_q;
  logic [2:0]           s2_kind_q;
  logic                 s2_boxhit_q, s2_boxhit_d;
  logic signed [CW-1:0] s2_lox_q, s2_loy_q, s2_lox_d, s2_loy_d;
  logic signed [EW-1:0] s2_hix_q, s2_hiy_q, s2_hix_d, s2_hiy_d;
  logic signed [EW-1:0] s2_dx_q, s2_dy_q, s2_dx_d, s2_dy_d;
  logic [CW-1:0]        s2_r_q, s2_r_d;
  logic signed [CW-1:0] s2_px_q, s2_py_q, s2_px_d, s2_py_d;

  logic signed [EW-1:0] d1x, d1y, nd1x, nd1y, dx2, dy2;
  logic signed [WW-1:0] d2x, d2y;
  logic                 d1x_neg, d1y_neg, d2x_pos, d2y_pos;
  logic                 box_box_hit, box_pt_hit;
  logic signed [CW-1:0] cx, cy;

  // stage 3: squares and overlap centre
  logic                 s3_valid_q;
  logic [2:0]           s3_kind_q;
  logic                 s3_boxhit_q;
  logic [QW-1:0]        s3_sqx_q, s3_sqy_q, s3_sqx_d, s3_sqy_d;
  logic [RW-1:0]        s3_rsq_q, s3_rsq_d;
  logic signed [CW-1:0] s3_px_q, s3_py_q, s3_px_d, s3_py_d;

  logic signed [2*EW-1:0] sqx_full, sqy_full;
  logic signed [WW-1:0]   bsum_x, bsum_y;
  logic signed [EW-1:0]   bhalf_x, bhalf_y;
  logic signed [CW-1:0]   bsat_x, bsat_y;

  // stage 4: distance compare and result
  logic                 valid_q;
  sct_pkg::res_t        res_q, res_d;
  logic [QW:0]          dist_sq;
  logic                 circ_in;

  assign busy = 1'b0;

  // ---------------------------------------------------------------- stage 1
  assign s1_valid_d = start && !busy;
  assign s1_ar_d    = EW'($signed(req_i.a_x)) + $signed({2'b00, req_i.a_w});
  assign s1_ab_d    = EW'($signed(req_i.a_y)) + $signed({2'b00, req_i.a_h});
  assign s1_br_d    = EW'($signed(req_i.b_x)) + $signed({2'b00, req_i.b_w});
  assign s1_bb_d    = EW'($signed(req_i.b_y)) + $signed({2'b00, req_i.b_h});
  assign s1_msx_d   = EW'($signed(req_i.a_x)) + EW'($signed(req_i.b_x));
  assign s1_msy_d   = EW'($signed(req_i.a_y)) + EW'($signed(req_i.b_y));
  assign s1_rsum_d  = {1'b0, req_i.a_w} + {1'b0, req_i.b_w};

  // ---------------------------------------------------------------- stage 2
  assign d1x  = EW'(s1_bx_q) - EW'(s1_ax_q);
  assign d1y  = EW'(s1_by_q) - EW'(s1_ay_q);
  assign nd1x = EW'(s1_ax_q) - EW'(s1_bx_q);
  assign nd1y = EW'(s1_ay_q) - EW'(s1_by_q);
  assign d2x  = WW'(s1_bx_q) - WW'(s1_ar_q);
  assign d2y  = WW'(s1_by_q) - WW'(s1_ab_q);

  assign d1x_neg = d1x[EW-1];
  assign d1y_neg = d1y[EW-1];
  assign d2x_pos = !d2x[WW-1] && (|d2x);
  assign d2y_pos = !d2y[WW-1] && (|d2y);

  assign box_box_hit = !(d2x_pos || (EW'(s1_ax_q) > s1_br_q) ||
                         d2y_pos || (EW'(s1_ay_q) > s1_bb_q));
  assign box_pt_hit  = !(d2x_pos || d1x_neg || d2y_pos || d1y_neg);

  // clamp circle centre into the box
  assign dx2 = d1x_neg ? d1x : (d2x_pos ? $signed(d2x[EW-1:0]) : '0);
  assign dy2 = d1y_neg ? d1y : (d2y_pos ? $signed(d2y[EW-1:0]) : '0);
  assign cx  = d1x_neg ? s1_ax_q : (d2x_pos ? $signed(s1_ar_q[CW-1:0]) : s1_bx_q);
  assign cy  = d1y_neg ? s1_ay_q : (d2y_pos ? $signed(s1_ab_q[CW-1:0]) : s1_by_q);

  assign s2_lox_d = (s1_ax_q > s1_bx_q) ? s1_ax_q : s1_bx_q;
  assign s2_loy_d = (s1_ay_q > s1_by_q) ? s1_ay_q : s1_by_q;
  assign s2_hix_d = (s1_ar_q < s1_br_q) ? s1_ar_q : s1_br_q;
  assign s2_hiy_d = (s1_ab_q < s1_bb_q) ? s1_ab_q : s1_bb_q;

  always_comb begin
    s2_boxhit_d = 1'b0;
    s2_dx_d     = d1x;
    s2_dy_d     = d1y;
    s2_r_d      = {1'b0, s1_aw_q};
    s2_px_d     = s1_bx_q;
    s2_py_d     = s1_by_q;
    unique case (s1_kind_q)
      sct_pkg::ReqBoxBox: begin
        s2_boxhit_d = box_box_hit;
      end
      sct_pkg::ReqCircCirc: begin
        s2_dx_d = nd1x;
        s2_dy_d = nd1y;
        s2_r_d  = s1_rsum_q;
        s2_px_d = $signed(s1_msx_q[EW-1:1]);
        s2_py_d = $signed(s1_msy_q[EW-1:1]);
      end
      sct_pkg::ReqBoxCirc: begin
        s2_dx_d = dx2;
        s2_dy_d = dy2;
        s2_r_d  = {1'b0, s1_bw_q};
        s2_px_d = cx;
        s2_py_d = cy;
      end
      sct_pkg::ReqBoxPoint: begin
        s2_boxhit_d = box_pt_hit;
      end
      sct_pkg::ReqCircPoint: begin
        s2_r_d = {1'b0, s1_aw_q};
      end
      default: begin
        s2_boxhit_d = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- stage 3
  assign sqx_full = (2 * EW)'(s2_dx_q) * (2 * EW)'(s2_dx_q);
  assign sqy_full = (2 * EW)'(s2_dy_q) * (2 * EW)'(s2_dy_q);
  assign s3_sqx_d = sqx_full[QW-1:0];
  assign s3_sqy_d = sqy_full[QW-1:0];
  assign s3_rsq_d = RW'(s2_r_q) * RW'(s2_r_q);

  assign bsum_x  = WW'(s2_lox_q) + WW'(s2_hix_q);
  assign bsum_y  = WW'(s2_loy_q) + WW'(s2_hiy_q);
  assign bhalf_x = $signed(bsum_x[WW-1:1]);
  assign bhalf_y = $signed(bsum_y[WW-1:1]);
  assign bsat_x  = (bhalf_x[EW-1] == bhalf_x[CW-1]) ? $signed(bhalf_x[CW-1:0]) :
                   (bhalf_x[EW-1] ? CoordMin : CoordMax);
  assign bsat_y  = (bhalf_y[EW-1] == bhalf_y[CW-1]) ? $signed(bhalf_y[CW-1:0]) :
                   (bhalf_y[EW-1] ? CoordMin : CoordMax);

  assign s3_px_d = (s2_kind_q == sct_pkg::ReqBoxBox) ? bsat_x : s2_px_q;
  assign s3_py_d = (s2_kind_q == sct_pkg::ReqBoxBox) ? bsat_y : s2_py_q;

  // ---------------------------------------------------------------- stage 4
  assign dist_sq = (QW + 1)'(s3_sqx_q) + (QW + 1)'(s3_sqy_q);
  assign circ_in = dist_sq <= (QW + 1)'(s3_rsq_q);

  always_comb begin
    res_d.hit = 1'b0;
    unique case (s3_kind_q)
      sct_pkg::ReqBoxBox,
      sct_pkg::ReqBoxPoint:  res_d.hit = s3_boxhit_q;
      sct_pkg::ReqCircCirc,
      sct_pkg::ReqBoxCirc,
      sct_pkg::ReqCircPoint: res_d.hit = circ_in;
      default:               res_d.hit = 1'b0;
    endcase
    res_d.hit_x = res_d.hit ? s3_px_q : '0;
    res_d.hit_y = res_d.hit ? s3_py_q : '0;
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      valid_q    <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_d) begin
      s1_kind_q <= req_i.req_type;
      s1_ax_q   <= $signed(req_i.a_x);
      s1_ay_q   <= $signed(req_i.a_y);
      s1_bx_q   <= $signed(req_i.b_x);
      s1_by_q   <= $signed(req_i.b_y);
      s1_aw_q   <= req_i.a_w;
      s1_bw_q   <= req_i.b_w;
      s1_ar_q   <= s1_ar_d;
      s1_ab_q   <= s1_ab_d;
      s1_br_q   <= s1_br_d;
      s1_bb_q   <= s1_bb_d;
      s1_msx_q  <= s1_msx_d;
      s1_msy_q  <= s1_msy_d;
      s1_rsum_q <= s1_rsum_d;
    end
    if (s1_valid_q) begin
      s2_kind_q   <= s1_kind_q;
      s2_boxhit_q <= s2_boxhit_d;
      s2_lox_q    <= s2_lox_d;
      s2_loy_q    <= s2_loy_d;
      s2_hix_q    <= s2_hix_d;
      s2_hiy_q    <= s2_hiy_d;
      s2_dx_q     <= s2_dx_d;
      s2_dy_q     <= s2_dy_d;
      s2_r_q      <= s2_r_d;
      s2_px_q     <= s2_px_d;
      s2_py_q     <= s2_py_d;
    end
    if (s2_valid_q) begin
      s3_kind_q   <= s2_kind_q;
      s3_boxhit_q <= s2_boxhit_q;
      s3_sqx_q    <= s3_sqx_d;
      s3_sqy_q    <= s3_sqy_d;
      s3_rsq_q    <= s3_rsq_d;
      s3_px_q     <= s3_px_d;
      s3_py_q     <= s3_py_d;
    end
    if (s3_valid_q) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
